// ===== src/bwbq_pkg.sv =====
// Shared widths, register index codes and the round-and-saturate helper for the
// three-channel Butterworth low-pass biquad unit.
// Depends on nothing; used by the unit and its checker.
`default_nettype none

package bwbq_pkg;

	localparam int SAMPLE_W  = 16;                   // joint sample and filtered value
	localparam int B0_W      = 17;                   // unsigned Q1.16 feedforward gain
	localparam int COEF_W    = 18;                   // signed Q2.16 feedback coefficients
	localparam int CFG_IDX_W = 2;
	localparam int XSUM_W    = SAMPLE_W + 3;         // x0 + 2*x1 + x2
	localparam int PB_W      = COEF_W + XSUM_W;      // b0 * (x0 + 2*x1 + x2)
	localparam int PA_W      = COEF_W + SAMPLE_W;    // a * y
	localparam int ACC_W     = PB_W + 2;
	localparam int FRAC_W    = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_B0 = 2'd0,
		CFG_A1 = 2'd1,
		CFG_A2 = 2'd2
	} cfg_index_t;

	// Round to nearest with ties toward plus infinity, then clamp to 16 bits.
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-1:0] scaled;
		logic signed [ACC_W-1:0] sat_hi;
		logic signed [ACC_W-1:0] sat_lo;
		logic signed [SAMPLE_W-1:0] res;
		sat_hi = ACC_W'(32767);
		sat_lo = ACC_W'(-32768);
		biased = acc + (ACC_W'(1) <<< (FRAC_W - 1));
		scaled = biased >>> FRAC_W;
		if (scaled > sat_hi) begin
			res = SAMPLE_W'(32767);
		end else if (scaled < sat_lo) begin
			res = SAMPLE_W'(-32768);
		end else begin
			res = scaled[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== src/butterworth_biquad_three_channel_unit.sv =====
// Multi-channel second-order Butterworth low-pass biquad, direct form I, with
// shared coefficients written through a plain register port.
// Depends on bwbq_pkg.
//
// Usage:
//   s_axis carries one request per sample period: one signed 16-bit current per
//   joint in tdata, joint one in the lowest bits. m_axis returns one request
//   with the filtered values in the same layout. coef_b0, coef_a1 and coef_a2
//   are written on cfg_we/cfg_index/cfg_data while the filter is idle.
//   Samples pass the input register x_s1, then the output register m_data_q.
//   Throughput is one request per cycle while m_axis_tready is high; the
//   limit is the per-channel feedback, where the five-tap multiply-add and
//   the rounding close combinationally through the past-output registers.
//   Reset clears the coefficients, the past inputs and outputs of every
//   channel and the valid flags of both pipeline stages, so the filter
//   starts from rest and gives zeros until the coefficients are written.
//   When m_axis_tready is low with a result waiting, the result is held and
//   the input register holds one more sample; s_axis_tready then drops.
`default_nettype none

module butterworth_biquad_three_channel_unit #(
	parameter int CHANNELS = 3
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic [bwbq_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [bwbq_pkg::COEF_W-1:0]              cfg_data,
	input  wire logic                                     s_axis_tvalid,
	output logic                                          s_axis_tready,
	// sample_joint_one, sample_joint_two, sample_joint_three, ... (16 bits each)
	input  wire logic [CHANNELS*bwbq_pkg::SAMPLE_W-1:0]   s_axis_tdata,
	output logic                                          m_axis_tvalid,
	input  wire logic                                     m_axis_tready,
	// filtered_joint_one, filtered_joint_two, filtered_joint_three, ... (16 bits each)
	output logic [CHANNELS*bwbq_pkg::SAMPLE_W-1:0]        m_axis_tdata
);

	localparam int SW = bwbq_pkg::SAMPLE_W;
	localparam int DW = CHANNELS * SW;

	logic [bwbq_pkg::B0_W-1:0]          coef_b0_q;
	logic signed [bwbq_pkg::COEF_W-1:0] coef_a1_q;
	logic signed [bwbq_pkg::COEF_W-1:0] coef_a2_q;

	logic          valid_s1;
	logic [DW-1:0] x_s1;
	logic          m_valid_q;
	logic [DW-1:0] m_data_q;
	logic          advance;

	logic signed [SW-1:0] x1_q [CHANNELS];
	logic signed [SW-1:0] x2_q [CHANNELS];
	logic signed [SW-1:0] y1_q [CHANNELS];
	logic signed [SW-1:0] y2_q [CHANNELS];

	logic signed [SW-1:0]               x0     [CHANNELS];
	logic signed [bwbq_pkg::XSUM_W-1:0] xsum   [CHANNELS];
	logic signed [bwbq_pkg::PB_W-1:0]   pb     [CHANNELS];
	logic signed [bwbq_pkg::PA_W-1:0]   pa1    [CHANNELS];
	logic signed [bwbq_pkg::PA_W-1:0]   pa2    [CHANNELS];
	logic signed [bwbq_pkg::ACC_W-1:0]  acc    [CHANNELS];
	logic signed [SW-1:0]               y_next [CHANNELS];
	logic signed [bwbq_pkg::COEF_W-1:0] b0_s;

	// The whole pipe moves whenever the output register is free or being taken.
	assign advance       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign b0_s = $signed({1'b0, coef_b0_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= '0;
			coef_a1_q <= '0;
			coef_a2_q <= '0;
		end else if (cfg_we) begin
			unique case (bwbq_pkg::cfg_index_t'(cfg_index))
				bwbq_pkg::CFG_B0: coef_b0_q <= cfg_data[bwbq_pkg::B0_W-1:0];
				bwbq_pkg::CFG_A1: coef_a1_q <= $signed(cfg_data);
				bwbq_pkg::CFG_A2: coef_a2_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			x0[c]   = $signed(x_s1[c*SW +: SW]);
			// b1 = 2*b0 and b2 = b0, so the feedforward taps fold into one product.
			xsum[c] = bwbq_pkg::XSUM_W'(x0[c]) + (bwbq_pkg::XSUM_W'(x1_q[c]) <<< 1)
			        + bwbq_pkg::XSUM_W'(x2_q[c]);
			pb[c]   = b0_s * xsum[c];
			pa1[c]  = coef_a1_q * y1_q[c];
			pa2[c]  = coef_a2_q * y2_q[c];
			acc[c]  = bwbq_pkg::ACC_W'(pb[c]) - bwbq_pkg::ACC_W'(pa1[c])
			        - bwbq_pkg::ACC_W'(pa2[c]);
			y_next[c] = bwbq_pkg::round_sat(acc[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				x1_q[c] <= '0;
				x2_q[c] <= '0;
				y1_q[c] <= '0;
				y2_q[c] <= '0;
			end
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				m_valid_q <= valid_s1;
				if (valid_s1) begin
					for (int c = 0; c < CHANNELS; c++) begin
						x2_q[c] <= x1_q[c];
						x1_q[c] <= x0[c];
						y2_q[c] <= y1_q[c];
						y1_q[c] <= y_next[c];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			x_s1 <= s_axis_tdata;
		end
		if (advance && valid_s1) begin
			for (int c = 0; c < CHANNELS; c++) begin
				m_data_q[c*SW +: SW] <= y_next[c];
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/bwbq_checker.sv =====
// Port-level checks for the multi-channel biquad unit, attached by bind.
// Depends on bwbq_pkg and on butterworth_biquad_three_channel_unit.
`default_nettype none

module bwbq_checker #(
	parameter int CHANNELS = 3
) (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   s_axis_tvalid,
	input wire logic                                   s_axis_tready,
	input wire logic                                   m_axis_tvalid,
	input wire logic                                   m_axis_tready,
	input wire logic [CHANNELS*bwbq_pkg::SAMPLE_W-1:0] m_axis_tdata
);

	// A waiting result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The input side only stalls because a result is waiting downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without downstream backpressure");

	// A ready sink means the filter is ready for a new sample in the same cycle.
	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input not ready while output is drained");

	// A fresh result follows an accepted sample through the input and output registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result appeared without an accepted sample");

endmodule

bind butterworth_biquad_three_channel_unit bwbq_checker #(.CHANNELS(CHANNELS)) u_bwbq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
